// File: src/letterbox_point_mapper_top_defines.svh
// ----------------------------------------------------------------------------
// Letterbox point mapper assertion macros
// Concurrent assertion wrappers shared by the RTL files of the block. Defining
// ASSERT_OFF compiles every use of them away.
// ----------------------------------------------------------------------------
`ifndef LETTERBOX_POINT_MAPPER_TOP_DEFINES_SVH
`define LETTERBOX_POINT_MAPPER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising edge, switched off while reset is high.
`define LBPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every rising edge, reset included.
`define LBPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBPM_ASSERT(lbl, clk, rst, prop, msg)
`define LBPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/lbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox point mapper package
// Default widths, reset sizes, register indexes, fit sequencer states and the
// width helpers shared by the fit unit, the axis pipelines and the top level.
// ----------------------------------------------------------------------------
package lbpm_pkg;

   localparam int COORD_BITS_DEF    = 16;
   localparam int SIZE_BITS_DEF     = 14;

   localparam int RESET_REAL_WIDTH  = 1920;
   localparam int RESET_REAL_HEIGHT = 1080;
   localparam int RESET_USER_WIDTH  = 1920;
   localparam int RESET_USER_HEIGHT = 1080;

   localparam int CSR_INDEX_BITS    = 2;
   localparam int PIPE_STAGES       = 6;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REAL_WIDTH  = 2'd0,
      CSR_REAL_HEIGHT = 2'd1,
      CSR_USER_WIDTH  = 2'd2,
      CSR_USER_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FIT_PROD,
      FIT_SEL,
      FIT_DIV_SIZE,
      FIT_DIV_OFF,
      FIT_DIV_FWD,
      FIT_DIV_BWD,
      FIT_DONE
   } fit_state_type;

   // Width of a point magnitude: a full coordinate or a clamped fitted position.
   function automatic int mag_bits(int coord_bits, int size_bits);
      return (coord_bits > size_bits) ? coord_bits : size_bits;
   endfunction

   // Width of the rounding dividend 2*mag*n + d, also the reciprocal precision.
   function automatic int recip_bits(int coord_bits, int size_bits);
      return mag_bits(coord_bits, size_bits) + size_bits + 1;
   endfunction

endpackage

// File: src/lbpm_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox fit unit
// Holds the size registers and recomputes the fit (ratio, fitted size, band
// offsets and both scaling reciprocals) with one shared serial divider.
// ----------------------------------------------------------------------------
module lbpm_fit
   import lbpm_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]                      csr_index,
   input  logic [SIZE_BITS-1:0]                           csr_wdata,
   output logic                                           fit_ready,
   output logic [SIZE_BITS-1:0]                           ratio_num,
   output logic [SIZE_BITS-1:0]                           ratio_den,
   output logic [SIZE_BITS-1:0]                           fit_width,
   output logic [SIZE_BITS-1:0]                           fit_height,
   output logic [SIZE_BITS-2:0]                           off_x,
   output logic [SIZE_BITS-2:0]                           off_y,
   output logic [recip_bits(COORD_BITS, SIZE_BITS)-1:0]   recip_fwd,
   output logic [recip_bits(COORD_BITS, SIZE_BITS)-1:0]   recip_bwd
);

   localparam int SW  = SIZE_BITS;
   localparam int PW  = 2 * SW;
   localparam int VSW = SW + 1;
   localparam int K   = recip_bits(COORD_BITS, SIZE_BITS);
   localparam int DW  = K + 1;
   localparam int CW  = $clog2(DW);

   logic [SW-1:0]   real_w_ff, real_h_ff, user_w_ff, user_h_ff;
   logic [SW-1:0]   rw, rh, uw, uh;
   fit_state_type   state_ff, state_in;

   logic [PW-1:0]   prod_a_ff, prod_b_ff, diff_ff;
   logic            lt_ff;
   logic            is_lt;
   logic [SW-1:0]   num_ff, den_ff, fit_w_ff, fit_h_ff;
   logic [SW-2:0]   off_x_ff, off_y_ff;
   logic [K-1:0]    m_fwd_ff, m_bwd_ff;

   logic [VSW-1:0]  rem_ff, dvsr_ff, rem_step;
   logic [DW-1:0]   quo_ff, quo_step, one_k;
   logic [CW-1:0]   cnt_ff;
   logic [VSW:0]    trial, div_sub;
   logic            div_ge, div_last;
   logic [SW-1:0]   size_q;

   // A size register holding zero acts as one.
   assign rw = (real_w_ff == '0) ? SW'(1) : real_w_ff;
   assign rh = (real_h_ff == '0) ? SW'(1) : real_h_ff;
   assign uw = (user_w_ff == '0) ? SW'(1) : user_w_ff;
   assign uh = (user_h_ff == '0) ? SW'(1) : user_h_ff;

   // Restoring divider: one quotient bit per cycle.
   assign trial    = {rem_ff, quo_ff[DW-1]};
   assign div_ge   = trial >= {1'b0, dvsr_ff};
   assign div_sub  = trial - {1'b0, dvsr_ff};
   assign rem_step = div_ge ? div_sub[VSW-1:0] : trial[VSW-1:0];
   assign quo_step = {quo_ff[DW-2:0], div_ge};
   assign div_last = (cnt_ff == '0);
   assign one_k    = {1'b1, {K{1'b0}}};
   assign is_lt    = prod_a_ff < prod_b_ff;
   assign size_q   = (quo_step[SW-1:0] == '0) ? SW'(1) : quo_step[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         real_w_ff <= SW'(RESET_REAL_WIDTH);
         real_h_ff <= SW'(RESET_REAL_HEIGHT);
         user_w_ff <= SW'(RESET_USER_WIDTH);
         user_h_ff <= SW'(RESET_USER_HEIGHT);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REAL_WIDTH:  real_w_ff <= csr_wdata;
            CSR_REAL_HEIGHT: real_h_ff <= csr_wdata;
            CSR_USER_WIDTH:  user_w_ff <= csr_wdata;
            CSR_USER_HEIGHT: user_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIT_PROD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FIT_PROD:     state_in = FIT_SEL;
         FIT_SEL:      state_in = FIT_DIV_SIZE;
         FIT_DIV_SIZE: if (div_last) state_in = FIT_DIV_OFF;
         FIT_DIV_OFF:  if (div_last) state_in = FIT_DIV_FWD;
         FIT_DIV_FWD:  if (div_last) state_in = FIT_DIV_BWD;
         FIT_DIV_BWD:  if (div_last) state_in = FIT_DONE;
         FIT_DONE:     state_in = FIT_DONE;
         default:      state_in = FIT_PROD;
      endcase
      // Any register write restarts the fit from the top.
      if (csr_wr_en) begin
         state_in = FIT_PROD;
      end
   end

   assign fit_ready = (state_ff == FIT_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            FIT_SEL: cnt_ff <= CW'(DW - 1);
            FIT_DIV_SIZE, FIT_DIV_OFF, FIT_DIV_FWD, FIT_DIV_BWD: begin
               cnt_ff <= div_last ? CW'(DW - 1) : cnt_ff - CW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         FIT_PROD: begin
            prod_a_ff <= PW'(rw) * PW'(uh);
            prod_b_ff <= PW'(uw) * PW'(rh);
         end
         FIT_SEL: begin
            lt_ff  <= is_lt;
            rem_ff <= '0;
            if (is_lt) begin
               num_ff   <= rw;
               den_ff   <= uw;
               fit_w_ff <= rw;
               diff_ff  <= prod_b_ff - prod_a_ff;
               quo_ff   <= DW'(prod_a_ff);
               dvsr_ff  <= {1'b0, uw};
            end else begin
               num_ff   <= rh;
               den_ff   <= uh;
               fit_h_ff <= rh;
               diff_ff  <= prod_a_ff - prod_b_ff;
               quo_ff   <= DW'(prod_b_ff);
               dvsr_ff  <= {1'b0, uh};
            end
         end
         FIT_DIV_SIZE: begin
            rem_ff <= rem_step;
            quo_ff <= quo_step;
            if (div_last) begin
               if (lt_ff) begin
                  fit_h_ff <= size_q;
               end else begin
                  fit_w_ff <= size_q;
               end
               rem_ff  <= '0;
               quo_ff  <= DW'(diff_ff);
               dvsr_ff <= {den_ff, 1'b0};
            end
         end
         FIT_DIV_OFF: begin
            rem_ff <= rem_step;
            quo_ff <= quo_step;
            if (div_last) begin
               if (lt_ff) begin
                  off_x_ff <= '0;
                  off_y_ff <= quo_step[SW-2:0];
               end else begin
                  off_x_ff <= quo_step[SW-2:0];
                  off_y_ff <= '0;
               end
               rem_ff  <= '0;
               quo_ff  <= one_k;
               dvsr_ff <= {den_ff, 1'b0};
            end
         end
         FIT_DIV_FWD: begin
            rem_ff <= rem_step;
            quo_ff <= quo_step;
            if (div_last) begin
               m_fwd_ff <= quo_step[K-1:0];
               rem_ff   <= '0;
               quo_ff   <= one_k;
               dvsr_ff  <= {num_ff, 1'b0};
            end
         end
         FIT_DIV_BWD: begin
            rem_ff <= rem_step;
            quo_ff <= quo_step;
            if (div_last) begin
               m_bwd_ff <= quo_step[K-1:0];
            end
         end
         default: ;
      endcase
   end

   assign ratio_num  = num_ff;
   assign ratio_den  = den_ff;
   assign fit_width  = fit_w_ff;
   assign fit_height = fit_h_ff;
   assign off_x      = off_x_ff;
   assign off_y      = off_y_ff;
   assign recip_fwd  = m_fwd_ff;
   assign recip_bwd  = m_bwd_ff;

endmodule

// File: src/lbpm_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox axis pipeline
// Six-stage datapath mapping one coordinate: offset and clamp, rounding
// dividend, reciprocal multiply, remainder correction and saturation.
// ----------------------------------------------------------------------------
module lbpm_axis
   import lbpm_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic                                           clock,
   input  logic [PIPE_STAGES-1:0]                         stage_en,
   input  logic                                           func,
   input  logic signed [COORD_BITS-1:0]                   pos,
   input  logic [SIZE_BITS-2:0]                           off,
   input  logic [SIZE_BITS-1:0]                           fit,
   input  logic [SIZE_BITS-1:0]                           ratio_num,
   input  logic [SIZE_BITS-1:0]                           ratio_den,
   input  logic [recip_bits(COORD_BITS, SIZE_BITS)-1:0]   recip_fwd,
   input  logic [recip_bits(COORD_BITS, SIZE_BITS)-1:0]   recip_bwd,
   output logic signed [COORD_BITS-1:0]                   result
);

   localparam int SW = SIZE_BITS;
   localparam int MW = mag_bits(COORD_BITS, SIZE_BITS);
   localparam int K  = recip_bits(COORD_BITS, SIZE_BITS);
   localparam int W1 = MW + 2;
   localparam int VW = K + 2;
   localparam logic signed [VW-1:0] SAT_HI = {{(VW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [VW-1:0] SAT_LO = {{(VW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   // Stage 1: offset removal and clamp, or magnitude of the point.
   logic signed [W1-1:0] pos_w, off_w, fit_w, diff_w, v_shift, v_clamp, pos_abs;
   logic [MW-1:0]        mag1_in, mag1_ff;
   logic                 neg1_in, neg1_ff, func1_ff;

   assign pos_w   = W1'(pos);
   assign off_w   = $signed(W1'(off));
   assign fit_w   = $signed(W1'(fit));
   assign diff_w  = pos_w - off_w;
   assign v_shift = (pos_w <= off_w) ? '0 : diff_w;
   assign v_clamp = (v_shift >= fit_w) ? fit_w - W1'(1) : v_shift;
   assign pos_abs = pos_w[W1-1] ? -pos_w : pos_w;
   assign mag1_in = func ? v_clamp[MW-1:0] : pos_abs[MW-1:0];
   assign neg1_in = !func && pos[COORD_BITS-1];

   // Stage 2: rounding dividend N = 2*mag*n + d.
   logic [SW-1:0]    n_sel, d_sel;
   logic [MW+SW-1:0] prod2;
   logic [K-1:0]     n2_in, n2_ff;
   logic             neg2_ff, func2_ff;

   assign n_sel = func1_ff ? ratio_den : ratio_num;
   assign d_sel = func1_ff ? ratio_num : ratio_den;
   assign prod2 = (MW+SW)'(mag1_ff) * (MW+SW)'(n_sel);
   assign n2_in = {prod2, 1'b0} + K'(d_sel);

   // Stage 3: quotient estimate from the reciprocal of 2*d.
   logic [K-1:0]   m_sel, q3_in, q3_ff, n3_ff;
   logic [2*K-1:0] prod3;
   logic           neg3_ff, func3_ff;

   assign m_sel = func2_ff ? recip_bwd : recip_fwd;
   assign prod3 = (2*K)'(n2_ff) * (2*K)'(m_sel);
   assign q3_in = prod3[2*K-1:K];

   // Stage 4: estimate times divisor.
   logic [SW:0]     d4;
   logic [K+SW:0]   prod4;
   logic [K-1:0]    qd4_ff, q4_ff, n4_ff;
   logic            neg4_ff, func4_ff;

   assign d4    = {(func3_ff ? ratio_num : ratio_den), 1'b0};
   assign prod4 = (K+SW+1)'(q3_ff) * (K+SW+1)'(d4);

   // Stage 5: the estimate is low by at most one; the remainder settles it.
   logic [SW:0]  d5;
   logic [K-1:0] rem5, q5_in, q5_ff;
   logic         neg5_ff, func5_ff;

   assign d5    = {(func4_ff ? ratio_num : ratio_den), 1'b0};
   assign rem5  = n4_ff - qd4_ff;
   assign q5_in = q4_ff + K'(rem5 >= K'(d5));

   // Stage 6: sign, band offset and saturation.
   logic signed [VW-1:0]   q_s, val_s, sum_s;
   logic [SW-2:0]          off_add;
   logic [COORD_BITS-1:0]  out_in, out_ff;

   assign q_s     = $signed({2'b00, q5_ff});
   assign val_s   = neg5_ff ? -q_s : q_s;
   assign off_add = func5_ff ? '0 : off;
   assign sum_s   = val_s + $signed({{(VW-SW+1){1'b0}}, off_add});

   always_comb begin
      if (sum_s > SAT_HI) begin
         out_in = SAT_HI[COORD_BITS-1:0];
      end else if (sum_s < SAT_LO) begin
         out_in = SAT_LO[COORD_BITS-1:0];
      end else begin
         out_in = sum_s[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         func1_ff <= func;
      end
      if (stage_en[1]) begin
         n2_ff    <= n2_in;
         neg2_ff  <= neg1_ff;
         func2_ff <= func1_ff;
      end
      if (stage_en[2]) begin
         q3_ff    <= q3_in;
         n3_ff    <= n2_ff;
         neg3_ff  <= neg2_ff;
         func3_ff <= func2_ff;
      end
      if (stage_en[3]) begin
         qd4_ff   <= prod4[K-1:0];
         q4_ff    <= q3_ff;
         n4_ff    <= n3_ff;
         neg4_ff  <= neg3_ff;
         func4_ff <= func3_ff;
      end
      if (stage_en[4]) begin
         q5_ff    <= q5_in;
         neg5_ff  <= neg4_ff;
         func5_ff <= func4_ff;
      end
      if (stage_en[5]) begin
         out_ff   <= out_in;
      end
   end

   assign result = $signed(out_ff);

endmodule

// File: src/letterbox_point_mapper_top.sv
`timescale 1ns / 1ps
`include "letterbox_point_mapper_top_defines.svh"
// ----------------------------------------------------------------------------
// Letterbox point mapper
// Fits a user resolution into the physical display with its aspect ratio kept
// and maps points between the two spaces in either direction.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_*     in         req_valid/req_ready    req_func, req_pos_x, req_pos_y
//   rsp_*     out        rsp_valid/rsp_ready    rsp_out_x, rsp_out_y
//   csr_*     in         csr_wr_en (no wait)    csr_index, csr_wdata
//
// One item is accepted per cycle while no refit runs and the output is not
// stalled; its result passes through the six-stage axis pipelines.
// After reset and after every register write the fit is recomputed by one
// serial divider: a product step and a select step, then four divisions of
// DW = max(COORD_BITS, SIZE_BITS) + SIZE_BITS + 2 quotient bits each.
// req_ready stays low during that time.
// A stalled result holds the output stage and every full stage behind it;
// earlier stages keep filling their empty slots, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module letterbox_point_mapper_top
   import lbpm_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Point items in
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   // Mapped items out
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   // Size register writes
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [SIZE_BITS-1:0]          csr_wdata
);

   localparam int K = recip_bits(COORD_BITS, SIZE_BITS);

   // Fit results, constant while items flow.
   logic                  fit_ready;
   logic [SIZE_BITS-1:0]  ratio_num, ratio_den, fit_width, fit_height;
   logic [SIZE_BITS-2:0]  off_x, off_y;
   logic [K-1:0]          recip_fwd, recip_bwd;

   // One valid bit per pipeline stage; a stage loads when it is empty or
   // when the stage after it is loading too.
   logic [PIPE_STAGES-1:0] pipe_valid_ff, pipe_valid_in, stage_en;

   lbpm_fit #(
      .COORD_BITS (COORD_BITS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_fit (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fit_ready  (fit_ready),
      .ratio_num  (ratio_num),
      .ratio_den  (ratio_den),
      .fit_width  (fit_width),
      .fit_height (fit_height),
      .off_x      (off_x),
      .off_y      (off_y),
      .recip_fwd  (recip_fwd),
      .recip_bwd  (recip_bwd)
   );

   always_comb begin
      stage_en[PIPE_STAGES-1] = !pipe_valid_ff[PIPE_STAGES-1] || rsp_ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !pipe_valid_ff[i] || stage_en[i+1];
      end
   end

   assign req_ready = stage_en[0] && fit_ready;

   always_comb begin
      pipe_valid_in = pipe_valid_ff;
      if (stage_en[0]) begin
         pipe_valid_in[0] = req_valid && fit_ready;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (stage_en[i]) begin
            pipe_valid_in[i] = pipe_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   // The two axes share the control and differ only in position, offset and fitted size.
   lbpm_axis #(
      .COORD_BITS (COORD_BITS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_axis_x (
      .clock      (clock),
      .stage_en   (stage_en),
      .func       (req_func),
      .pos        (req_pos_x),
      .off        (off_x),
      .fit        (fit_width),
      .ratio_num  (ratio_num),
      .ratio_den  (ratio_den),
      .recip_fwd  (recip_fwd),
      .recip_bwd  (recip_bwd),
      .result     (rsp_out_x)
   );

   lbpm_axis #(
      .COORD_BITS (COORD_BITS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_axis_y (
      .clock      (clock),
      .stage_en   (stage_en),
      .func       (req_func),
      .pos        (req_pos_y),
      .off        (off_y),
      .fit        (fit_height),
      .ratio_num  (ratio_num),
      .ratio_den  (ratio_den),
      .recip_fwd  (recip_fwd),
      .recip_bwd  (recip_bwd),
      .result     (rsp_out_y)
   );

   assign rsp_valid = pipe_valid_ff[PIPE_STAGES-1];

   // A register write must close the input until the new fit is in place.
   `LBPM_ASSERT_ALWAYS(a_csr_blocks_input, clock, csr_wr_en |=> !req_ready, "item accepted during refit")

   // The second stage keeps its item while the stage after it is blocked.
   `LBPM_ASSERT(a_stage_holds, clock, reset, pipe_valid_ff[1] && !stage_en[2] |=> pipe_valid_ff[1], "pipeline stage dropped an item")

   // A finished fit never leaves a zero ratio, size or reciprocal behind.
   `LBPM_ASSERT(a_fit_nonzero, clock, reset, fit_ready |-> (ratio_num != '0 && ratio_den != '0 && fit_width != '0 && fit_height != '0 && recip_fwd != '0 && recip_bwd != '0), "degenerate fit values")

   // The leftover band lies on one axis only.
   `LBPM_ASSERT(a_one_band, clock, reset, fit_ready |-> (off_x == '0 || off_y == '0), "band offset on both axes")

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox point mapper testbench
// Sends point items in both directions under random idle gaps and result
// stalls, and checks each mapped item against a behavioral fit model. The
// run covers the reset sizes, zero and largest sizes, a degenerate fit,
// saturation and many random display and user resolutions.
// ----------------------------------------------------------------------------
module tb;
   import lbpm_pkg::*;

   localparam int     CW            = COORD_BITS_DEF;
   localparam int     SW            = SIZE_BITS_DEF;
   localparam logic   DIR_TO_REAL   = 1'b0;
   localparam logic   DIR_TO_USER   = 1'b1;
   localparam int     RANDOM_POINTS = 1900;
   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam longint COORD_MAX     = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint COORD_MIN     = -COORD_MAX - 1;
   localparam int     SIZE_TOP      = (1 << SW) - 1;
   localparam int     COMMON_SIZES [10] =
      '{480, 600, 720, 768, 1024, 1080, 1280, 1440, 1920, 2160};

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed { logic func; coord_type x; coord_type y; } point_req_type;
   typedef struct packed { coord_type x; coord_type y; } mapped_point_type;

   // Every input of the block starts at a known value.
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_func  = DIR_TO_REAL;
   coord_type                 req_pos_x = '0;
   coord_type                 req_pos_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   coord_type                 rsp_out_x;
   coord_type                 rsp_out_y;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_REAL_WIDTH;
   logic [SW-1:0]             csr_wdata = '0;

   // Points waiting to be sent, and mapped points waiting to come back.
   point_req_type    pending_points [$];
   mapped_point_type mapped_expect [$];
   mapped_point_type oldest_map;
   point_req_type    next_point;

   int points_queued   = 0;
   int points_accepted = 0;
   int error_count     = 0;
   int send_gap        = 0;
   int stall_left      = 0;
   int cycle_count     = 0;
   bit calm_phase      = 1'b0;

   // Mirror of the size registers and of the fit derived from them.
   logic [SW-1:0] size_reg [4];
   longint disp_w, disp_h, app_w, app_h;
   longint ratio_num, ratio_den, fit_w, fit_h, band_x, band_y;

   letterbox_point_mapper_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Fit model
   // ------------------------------------------------------------------------

   // Recomputes the scale, the fitted size and the band offsets. A size of
   // zero counts as one. The axis that fills the display fixes the scale,
   // and the leftover band on the other axis is split evenly, truncated.
   function automatic void refit_letterbox();
      disp_w = (size_reg[CSR_REAL_WIDTH]  == 0) ? 1 : size_reg[CSR_REAL_WIDTH];
      disp_h = (size_reg[CSR_REAL_HEIGHT] == 0) ? 1 : size_reg[CSR_REAL_HEIGHT];
      app_w  = (size_reg[CSR_USER_WIDTH]  == 0) ? 1 : size_reg[CSR_USER_WIDTH];
      app_h  = (size_reg[CSR_USER_HEIGHT] == 0) ? 1 : size_reg[CSR_USER_HEIGHT];
      if (disp_w * app_h < app_w * disp_h) begin
         ratio_num = disp_w;
         ratio_den = app_w;
         fit_w     = disp_w;
         fit_h     = (disp_w * app_h) / app_w;
         band_x    = 0;
         band_y    = (disp_h * app_w - disp_w * app_h) / (2 * app_w);
      end else begin
         ratio_num = disp_h;
         ratio_den = app_h;
         fit_w     = (disp_h * app_w) / app_h;
         fit_h     = disp_h;
         band_x    = (disp_w * app_h - disp_h * app_w) / (2 * app_h);
         band_y    = 0;
      end
      // A picture squeezed below one pixel still keeps one.
      if (fit_w == 0) fit_w = 1;
      if (fit_h == 0) fit_h = 1;
   endfunction

   // v * n / d, rounded half away from zero.
   function automatic longint scaled_round(longint v, longint n, longint d);
      longint mag, q;
      mag = ((v < 0) ? -v : v) * n;
      q   = (2 * mag + d) / (2 * d);
      return (v < 0) ? -q : q;
   endfunction

   function automatic coord_type clip_coord(longint v);
      if (v > COORD_MAX) return coord_type'(COORD_MAX);
      if (v < COORD_MIN) return coord_type'(COORD_MIN);
      return coord_type'(v);
   endfunction

   function automatic coord_type axis_to_user(longint p, longint off, longint fit);
      longint v;
      v = (p <= off) ? 0 : p - off;
      if (v >= fit) v = fit - 1;
      return clip_coord(scaled_round(v, ratio_den, ratio_num));
   endfunction

   function automatic mapped_point_type map_point(logic func, coord_type px,
                                                  coord_type py);
      mapped_point_type m;
      if (func == DIR_TO_REAL) begin
         m.x = clip_coord(scaled_round(longint'(px), ratio_num, ratio_den) + band_x);
         m.y = clip_coord(scaled_round(longint'(py), ratio_num, ratio_den) + band_y);
      end else begin
         m.x = axis_to_user(longint'(px), band_x, fit_w);
         m.y = axis_to_user(longint'(py), band_y, fit_h);
      end
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Most gaps are zero, many are short and a few are long. Calm phases run
   // both sides at full rate.
   function automatic int idle_cycles();
      int unsigned pick;
      if (calm_phase) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_size();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)  return $urandom_range(1, 8192);
      if (pick == 5) return $urandom_range(1, 16);
      if (pick == 6) return $urandom_range(0, SIZE_TOP);
      if (pick == 7) begin
         case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 8192;
            default: return SIZE_TOP;
         endcase
      end
      return COMMON_SIZES[$urandom_range(0, 9)];
   endfunction

   // Picks one coordinate. Most land in and just around the source picture,
   // so that bands, clamps and rounding are all exercised; the rest are raw
   // 16-bit values, fixed values around zero and the range ends, and the edges of the fitted area.
   function automatic coord_type pick_coord(logic func, bit horiz);
      longint span, off, fit;
      int unsigned pick;
      span = (func == DIR_TO_REAL) ? (horiz ? app_w : app_h)
                                   : (horiz ? disp_w : disp_h);
      off  = horiz ? band_x : band_y;
      fit  = horiz ? fit_w : fit_h;
      pick = $urandom_range(0, 9);
      if (pick < 2) return coord_type'($urandom);
      if (pick < 8) return clip_coord(longint'($urandom_range(0, int'(span) + 32)) - 16);
      case ($urandom_range(0, 8))
         0:       return coord_type'(COORD_MIN);
         1:       return coord_type'(COORD_MAX);
         2:       return coord_type'(-1);
         3:       return coord_type'(0);
         4:       return coord_type'(1);
         5:       return clip_coord(off);
         6:       return clip_coord(off + 1);
         7:       return clip_coord(off + fit - 1);
         default: return clip_coord(off + fit);
      endcase
   endfunction

   function automatic void enqueue_point(logic func, longint x, longint y);
      pending_points.push_back('{func, clip_coord(x), clip_coord(y)});
      points_queued++;
   endfunction

   // Writes the four size registers on consecutive cycles, once the block is
   // ready. Unless all are forced, a register is now and then left as it is,
   // and its write enable stays low for that cycle.
   task automatic program_sizes(int rw, int rh, int uw, int uh, bit all_regs);
      int value [4];
      value[CSR_REAL_WIDTH]  = rw;
      value[CSR_REAL_HEIGHT] = rh;
      value[CSR_USER_WIDTH]  = uw;
      value[CSR_USER_HEIGHT] = uh;
      while (!req_ready) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         if (all_regs || $urandom_range(0, 4) != 0) begin
            csr_wr_en   <= 1'b1;
            csr_index   <= csr_index_type'(i);
            csr_wdata   <= SW'(value[i]);
            size_reg[i]  = SW'(value[i]);
            refit_letterbox();
         end else begin
            csr_wr_en <= 1'b0;
         end
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Returns once every queued item has been accepted and every mapped item
   // has come back.
   task automatic wait_drained();
      while (points_accepted != points_queued || mapped_expect.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents one queued item at a time and records the mapped point
   // it should produce at the edge that accepts it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_valid && req_ready) begin
            mapped_expect.push_back(map_point(req_func, req_pos_x, req_pos_y));
            points_accepted++;
         end
         // The payload may only move once the current item is gone.
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || pending_points.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               next_point = pending_points.pop_front();
               req_valid <= 1'b1;
               req_func  <= next_point.func;
               req_pos_x <= next_point.x;
               req_pos_y <= next_point.y;
               send_gap   = idle_cycles();
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: stalls the result side at random and compares every accepted
   // result with the oldest mapped point still outstanding.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mapped_expect.size() == 0) begin
               $error("unexpected mapped item: out_x %0d, out_y %0d",
                      rsp_out_x, rsp_out_y);
               error_count++;
            end else begin
               oldest_map = mapped_expect.pop_front();
               if (rsp_out_x !== oldest_map.x) begin
                  $error("out_x mismatch: expected %0d, actual %0d",
                         oldest_map.x, rsp_out_x);
                  error_count++;
               end
               if (rsp_out_y !== oldest_map.y) begin
                  $error("out_y mismatch: expected %0d, actual %0d",
                         oldest_map.y, rsp_out_y);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = idle_cycles();
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[letterbox_point_mapper_top] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int  batch;
      int  random_sent;
      int  side_w, side_h;
      logic func;

      random_sent = 0;
      size_reg[CSR_REAL_WIDTH]  = RESET_REAL_WIDTH;
      size_reg[CSR_REAL_HEIGHT] = RESET_REAL_HEIGHT;
      size_reg[CSR_USER_WIDTH]  = RESET_USER_WIDTH;
      size_reg[CSR_USER_HEIGHT] = RESET_USER_HEIGHT;
      refit_letterbox();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes match, so both directions are the identity: the extremes
      // of the coordinate range pass through, and real to user clamps to the
      // picture.
      enqueue_point(DIR_TO_REAL, 0, 0);
      enqueue_point(DIR_TO_REAL, COORD_MIN, COORD_MIN);
      enqueue_point(DIR_TO_REAL, COORD_MAX, COORD_MAX);
      enqueue_point(DIR_TO_REAL, -1, 1);
      enqueue_point(DIR_TO_REAL, 1919, 1079);
      enqueue_point(DIR_TO_USER, 0, 0);
      enqueue_point(DIR_TO_USER, COORD_MIN, COORD_MAX);
      enqueue_point(DIR_TO_USER, COORD_MAX, COORD_MIN);
      enqueue_point(DIR_TO_USER, 1920, 1080);
      enqueue_point(DIR_TO_USER, 1919, 1079);
      wait_drained();

      // A 4:3 picture on a 16:9 display leaves bands at left and right.
      program_sizes(1920, 1080, 640, 480, 1'b1);
      enqueue_point(DIR_TO_REAL, 639, 479);
      enqueue_point(DIR_TO_REAL, -1, -1);
      enqueue_point(DIR_TO_USER, 240, 0);
      enqueue_point(DIR_TO_USER, 1679, 1079);
      wait_drained();

      // All sizes zero: every register acts as one.
      program_sizes(0, 0, 0, 0, 1'b1);
      enqueue_point(DIR_TO_REAL, 5, -5);
      enqueue_point(DIR_TO_USER, 5, -5);
      wait_drained();

      // A one pixel wide display under a very wide picture: the fitted height
      // truncates to zero and is held at one.
      program_sizes(1, 8192, 8192, 1, 1'b1);
      enqueue_point(DIR_TO_USER, 0, 0);
      enqueue_point(DIR_TO_USER, 9000, 4096);
      enqueue_point(DIR_TO_REAL, 8191, 0);
      wait_drained();

      // Largest sizes the registers hold over a one pixel picture: scaling
      // overflows and results saturate.
      program_sizes(SIZE_TOP, SIZE_TOP, 1, 1, 1'b1);
      enqueue_point(DIR_TO_REAL, COORD_MAX, COORD_MIN);
      enqueue_point(DIR_TO_REAL, 3, -3);
      enqueue_point(DIR_TO_USER, SIZE_TOP, SIZE_TOP);
      wait_drained();

      // Random phases: new sizes, some of them equal on both sides, then a
      // batch of random points. Writes only happen once the block is drained.
      while (random_sent < RANDOM_POINTS) begin
         calm_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            side_w = pick_size();
            side_h = pick_size();
            program_sizes(side_w, side_h, side_w, side_h, 1'b1);
         end else begin
            program_sizes(pick_size(), pick_size(), pick_size(), pick_size(), 1'b0);
         end
         batch = $urandom_range(60, 130);
         repeat (batch) begin
            func = 1'($urandom_range(0, 1));
            enqueue_point(func, pick_coord(func, 1'b1), pick_coord(func, 1'b0));
         end
         random_sent += batch;
         wait_drained();
      end

      // Keep the clock running so that a stray extra result still shows up.
      repeat (4 * PIPE_STAGES) @(posedge clock);
      if (error_count == 0) begin
         $display("[letterbox_point_mapper_top] OK");
      end else begin
         $display("[letterbox_point_mapper_top] ERROR");
      end
      $finish;
   end

endmodule
